### rtl/tsuq_pkg.sv
// Shared types and constants for the time-sorted unload queue.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package tsuq_pkg;

  localparam int DefaultDepth = 32;
  localparam int PosW = 8;
  localparam int TimeW = 32;
  localparam int CountW = 6;

  localparam logic [PosW-1:0] EmptyPosition = 8'hFF;

  // Operation codes of a request word. Code 3 has no meaning and is a no-op.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // One stored queue entry.
  typedef struct packed {
    logic [PosW-1:0] position;
    logic signed [TimeW-1:0] due_time;
  } entry_t;

  // Response word handed from the sequencer to the output register.
  typedef struct packed {
    logic head_valid;
    logic [PosW-1:0] head_position;
    logic signed [TimeW-1:0] head_time;
    logic [CountW-1:0] entry_count;
    logic rejected;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_POP_SHIFT,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

### rtl/tsuq_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on tsuq_pkg for the field widths.
`default_nettype none

interface tsuq_req_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [tsuq_pkg::PosW-1:0] position_number;
  logic signed [tsuq_pkg::TimeW-1:0] due_time;

  modport source(output valid, operation, position_number, due_time, input ready);
  modport sink(input valid, operation, position_number, due_time, output ready);
endinterface

interface tsuq_rsp_if;
  logic valid;
  logic ready;
  logic head_valid;
  logic [tsuq_pkg::PosW-1:0] head_position;
  logic signed [tsuq_pkg::TimeW-1:0] head_time;
  logic [tsuq_pkg::CountW-1:0] entry_count;
  logic rejected;

  modport source(output valid, head_valid, head_position, head_time, entry_count, rejected,
                 input ready);
  modport sink(input valid, head_valid, head_position, head_time, entry_count, rejected,
               output ready);
endinterface

`default_nettype wire

### rtl/tsuq_ram.sv
// Slot memory of the queue: one write port and one registered read port.
// Depends on tsuq_pkg for the entry type.
`default_nettype none

module tsuq_ram #(
  parameter int Depth = tsuq_pkg::DefaultDepth,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic clk,
  input  wire logic rd_en,
  input  wire logic [AddrW-1:0] rd_addr,
  output tsuq_pkg::entry_t rd_data,
  input  wire logic wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire tsuq_pkg::entry_t wr_data
);

  tsuq_pkg::entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/tsuq_seq.sv
// Sequencer of the queue: walks the slot memory one entry per cycle through
// a single signed time comparator. Depends on tsuq_pkg.
`default_nettype none

module tsuq_seq #(
  parameter int Depth = tsuq_pkg::DefaultDepth,
  localparam int AddrW = $clog2(Depth),
  localparam int CntW = $clog2(Depth + 1)
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire tsuq_pkg::op_t operation,
  input  wire logic [tsuq_pkg::PosW-1:0] position_number,
  input  wire logic signed [tsuq_pkg::TimeW-1:0] due_time,
  output logic idle,
  output logic res_valid,
  output tsuq_pkg::result_t res,
  input  wire logic res_take,
  output logic rd_en,
  output logic [AddrW-1:0] rd_addr,
  input  wire tsuq_pkg::entry_t rd_data,
  output logic wr_en,
  output logic [AddrW-1:0] wr_addr,
  output tsuq_pkg::entry_t wr_data
);

  tsuq_pkg::state_t state;
  tsuq_pkg::state_t state_next;
  logic [CntW-1:0] count;
  logic [AddrW-1:0] idx;
  tsuq_pkg::entry_t new_entry;
  logic rejected;

  logic empty;
  logic full;
  logic single;
  logic later;
  logic at_bottom;
  logic pop_last;
  logic [CntW-1:0] idx_w;
  logic [CntW+tsuq_pkg::CountW-1:0] cnt_ext;
  tsuq_pkg::entry_t in_entry;

  assign empty = (count == '0);
  assign full = (count == CntW'(Depth));
  assign single = (count == CntW'(1));
  assign idx_w = CntW'(idx);
  // The one comparator: is the stored entry due strictly later than the new one?
  assign later = ($signed(rd_data.due_time) > $signed(new_entry.due_time));
  assign at_bottom = (idx == AddrW'(1));
  assign pop_last = ((idx_w + CntW'(2)) == count);
  assign in_entry = '{position: position_number, due_time: due_time};

  always_comb begin
    state_next = state;
    case (state)
      tsuq_pkg::ST_IDLE: begin
        if (start) begin
          case (operation)
            tsuq_pkg::OP_INSERT: begin
              state_next = (full || empty) ? tsuq_pkg::ST_HEAD_RD : tsuq_pkg::ST_INS_CMP;
            end
            tsuq_pkg::OP_POP: begin
              state_next = (empty || single) ? tsuq_pkg::ST_HEAD_RD : tsuq_pkg::ST_POP_SHIFT;
            end
            default: begin
              state_next = tsuq_pkg::ST_HEAD_RD;
            end
          endcase
        end
      end
      tsuq_pkg::ST_INS_CMP: begin
        if (later) begin
          state_next = at_bottom ? tsuq_pkg::ST_INS_PUT : tsuq_pkg::ST_INS_CMP;
        end else begin
          state_next = tsuq_pkg::ST_HEAD_RD;
        end
      end
      tsuq_pkg::ST_INS_PUT: state_next = tsuq_pkg::ST_HEAD_RD;
      tsuq_pkg::ST_POP_SHIFT: begin
        state_next = pop_last ? tsuq_pkg::ST_HEAD_RD : tsuq_pkg::ST_POP_SHIFT;
      end
      tsuq_pkg::ST_HEAD_RD: state_next = tsuq_pkg::ST_HEAD_WAIT;
      tsuq_pkg::ST_HEAD_WAIT: state_next = tsuq_pkg::ST_RESULT;
      tsuq_pkg::ST_RESULT: begin
        if (res_take) begin
          state_next = tsuq_pkg::ST_IDLE;
        end
      end
      default: state_next = tsuq_pkg::ST_IDLE;
    endcase
  end

  // Memory port control. Reads run one entry ahead of the write they feed.
  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = new_entry;
    case (state)
      tsuq_pkg::ST_IDLE: begin
        if (start && operation == tsuq_pkg::OP_INSERT && !full) begin
          if (empty) begin
            wr_en = 1'b1;
            wr_data = in_entry;
          end else begin
            rd_en = 1'b1;
            rd_addr = AddrW'(count - CntW'(1));
          end
        end else if (start && operation == tsuq_pkg::OP_POP && !empty && !single) begin
          rd_en = 1'b1;
          rd_addr = AddrW'(1);
        end
      end
      tsuq_pkg::ST_INS_CMP: begin
        wr_en = 1'b1;
        wr_addr = idx;
        if (later) begin
          wr_data = rd_data;
          if (!at_bottom) begin
            rd_en = 1'b1;
            rd_addr = idx - AddrW'(2);
          end
        end
      end
      tsuq_pkg::ST_INS_PUT: begin
        wr_en = 1'b1;
        wr_addr = idx;
      end
      tsuq_pkg::ST_POP_SHIFT: begin
        wr_en = 1'b1;
        wr_addr = idx;
        wr_data = rd_data;
        if (!pop_last) begin
          rd_en = 1'b1;
          rd_addr = AddrW'(idx_w + CntW'(2));
        end
      end
      tsuq_pkg::ST_HEAD_RD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsuq_pkg::ST_IDLE;
      count <= '0;
      rejected <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        tsuq_pkg::ST_IDLE: begin
          if (start) begin
            new_entry <= in_entry;
            rejected <= 1'b0;
            case (operation)
              tsuq_pkg::OP_INSERT: begin
                if (full) begin
                  rejected <= 1'b1;
                end else if (empty) begin
                  count <= count + CntW'(1);
                end else begin
                  idx <= AddrW'(count);
                end
              end
              tsuq_pkg::OP_POP: begin
                if (empty) begin
                  rejected <= 1'b1;
                end else if (single) begin
                  count <= '0;
                end else begin
                  idx <= '0;
                end
              end
              tsuq_pkg::OP_CLEAR: count <= '0;
              default: begin
              end
            endcase
          end
        end
        tsuq_pkg::ST_INS_CMP: begin
          if (later) begin
            idx <= idx - AddrW'(1);
          end else begin
            count <= count + CntW'(1);
          end
        end
        tsuq_pkg::ST_INS_PUT: count <= count + CntW'(1);
        tsuq_pkg::ST_POP_SHIFT: begin
          if (pop_last) begin
            count <= count - CntW'(1);
          end else begin
            idx <= idx + AddrW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_ext = {{tsuq_pkg::CountW{1'b0}}, count};

  always_comb begin
    res.head_valid = !empty;
    res.head_position = empty ? tsuq_pkg::EmptyPosition : rd_data.position;
    res.head_time = empty ? '0 : rd_data.due_time;
    res.entry_count = cnt_ext[tsuq_pkg::CountW-1:0];
    res.rejected = rejected;
  end

  assign idle = (state == tsuq_pkg::ST_IDLE);
  assign res_valid = (state == tsuq_pkg::ST_RESULT);

endmodule

`default_nettype wire

### rtl/time_sorted_unload_queue.sv
// Time-sorted unload queue: up to DEPTH entries kept in ascending due-time order.
// An insert into a queue that is neither empty nor full walks back from the tail, moving
// each later entry back one slot; a pop moves every entry after the head forward one slot;
// an insert into an empty queue, a refused word, clear and no-op go straight to the head read.
// Throughput is one word at a time, bounded by the single memory walk.
// Reset (synchronous, active high) empties the queue; the slot memory is not cleared.
`default_nettype none

module time_sorted_unload_queue #(
  parameter int DEPTH = tsuq_pkg::DefaultDepth
) (
  input wire logic clk,
  input wire logic rst,
  tsuq_req_if.sink req,
  tsuq_rsp_if.source rsp
);

  localparam int AddrW = $clog2(DEPTH);

  // The queue lives in a single-port-read, single-port-write slot memory.
  // Entries at and beyond the fill count never reach a response, so neither reset nor
  // clear has to sweep the memory: the count alone marks what is held.
  logic rd_en;
  logic [AddrW-1:0] rd_addr;
  tsuq_pkg::entry_t rd_data;
  logic wr_en;
  logic [AddrW-1:0] wr_addr;
  tsuq_pkg::entry_t wr_data;

  logic seq_idle;
  logic start;
  logic res_valid;
  logic res_take;
  tsuq_pkg::result_t res;

  // Output register: it holds a finished response so the sequencer can go back
  // to idle and take the next request word while the response waits.
  logic out_valid;
  tsuq_pkg::result_t out_data;

  assign req.ready = seq_idle;
  assign start = req.valid && seq_idle;
  assign res_take = res_valid && (!out_valid || rsp.ready);

  tsuq_ram #(
    .Depth(DEPTH)
  ) u_ram (
    .clk(clk),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // The sequencer finds the insert point by walking from the tail toward the
  // head, moving each later entry back by one slot as it goes, so the search
  // and the shift share one pass and one comparator. A pop walks the other way.
  tsuq_seq #(
    .Depth(DEPTH)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .operation(tsuq_pkg::op_t'(req.operation)),
    .position_number(req.position_number),
    .due_time(req.due_time),
    .idle(seq_idle),
    .res_valid(res_valid),
    .res(res),
    .res_take(res_take),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.head_valid = out_data.head_valid;
  assign rsp.head_position = out_data.head_position;
  assign rsp.head_time = out_data.head_time;
  assign rsp.entry_count = out_data.entry_count;
  assign rsp.rejected = out_data.rejected;

endmodule

`default_nettype wire

### tb/time_sorted_unload_queue_test.sv
// Self-checking testbench for the time-sorted unload queue.
// Depends on tsuq_pkg, the channel interfaces in tsuq_if.sv and the queue RTL.
`timescale 1ns / 1ps

module time_sorted_unload_queue_test;

  localparam int Depth = tsuq_pkg::DefaultDepth;
  localparam int PosW = tsuq_pkg::PosW;
  localparam int TimeW = tsuq_pkg::TimeW;
  localparam int CountW = tsuq_pkg::CountW;
  localparam int RandomItems = 850;
  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int HangLimit = 1500;
  // Quiet cycles after the last result, longer than the slowest queue walk.
  localparam int DrainCycles = 60;
  // Operation code with no meaning; the block must leave the queue alone.
  localparam logic [1:0] OpNoEffect = 2'd3;

  // Mirror of the queue contents. Every accepted request word is applied to the
  // mirror at once, and the head it predicts is queued until the block's own
  // response word arrives; responses come back in request order.
  class queue_mirror;
    tsuq_pkg::entry_t slot[Depth];
    int fill;
    tsuq_pkg::result_t pending_heads[$];
    int error_count;

    function new();
      error_count = 0;
      empty_all();
    endfunction

    function void empty_all();
      int i;
      for (i = 0; i < Depth; i++) begin
        slot[i].position = tsuq_pkg::EmptyPosition;
        slot[i].due_time = '0;
      end
      fill = 0;
    endfunction

    function void note_request(logic [1:0] op, logic [PosW-1:0] pos,
                               logic signed [TimeW-1:0] due);
      tsuq_pkg::result_t head;
      logic refused;
      int n;
      int i;
      refused = 1'b0;
      case (op)
        tsuq_pkg::OP_INSERT: begin
          if (fill >= Depth) begin
            refused = 1'b1;
          end else begin
            // Skip every entry due at or before the new one, so ties keep arrival order.
            n = 0;
            while (n < fill && !($signed(slot[n].due_time) > due)) n++;
            for (i = fill; i > n; i--) slot[i] = slot[i-1];
            slot[n].position = pos;
            slot[n].due_time = due;
            fill++;
          end
        end
        tsuq_pkg::OP_POP: begin
          if (fill == 0) begin
            refused = 1'b1;
          end else begin
            for (i = 0; i + 1 < Depth; i++) slot[i] = slot[i+1];
            slot[Depth-1].position = tsuq_pkg::EmptyPosition;
            slot[Depth-1].due_time = '0;
            fill--;
            slot[fill].position = tsuq_pkg::EmptyPosition;
            slot[fill].due_time = '0;
          end
        end
        tsuq_pkg::OP_CLEAR: empty_all();
        default: ;
      endcase
      head.head_valid = (fill > 0);
      head.head_position = (fill > 0) ? slot[0].position : tsuq_pkg::EmptyPosition;
      head.head_time = (fill > 0) ? slot[0].due_time : '0;
      head.entry_count = CountW'(fill);
      head.rejected = refused;
      pending_heads.push_back(head);
    endfunction

    function void compare_field(string label, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        error_count++;
      end
    endfunction

    function void check_head(logic hv, logic [PosW-1:0] hp, logic signed [TimeW-1:0] ht,
                             logic [CountW-1:0] cnt, logic rj);
      tsuq_pkg::result_t want;
      if (pending_heads.size() == 0) begin
        $display("%0t: unexpected response word, expected none, actual %0d/%0d/%0d/%0d/%0d",
                 $time, hv, hp, ht, cnt, rj);
        error_count++;
        return;
      end
      want = pending_heads.pop_front();
      compare_field("head_valid", longint'(want.head_valid), longint'(hv));
      compare_field("head_position", longint'(want.head_position), longint'(hp));
      compare_field("head_time", longint'($signed(want.head_time)), longint'(ht));
      compare_field("entry_count", longint'(want.entry_count), longint'(cnt));
      compare_field("rejected", longint'(want.rejected), longint'(rj));
    endfunction
  endclass

  logic clk;
  logic rst;

  tsuq_req_if req_ch();
  tsuq_rsp_if rsp_ch();

  time_sorted_unload_queue #(.DEPTH(Depth)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  queue_mirror mirror = new();

  // Number of request words accepted so far, and a rough count of held entries
  // that the stimulus uses to steer the queue toward full and toward empty.
  int words_sent;
  int level;
  logic no_gaps;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset is asserted at the start and never asserted again.
  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Gap lengths: usually none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Random position number over the whole field, the reserved value included.
  function automatic logic [PosW-1:0] pick_pos();
    return PosW'($urandom_range(0, 255));
  endfunction

  // Due times: mostly a narrow band so that ties are common, plus the full range
  // and the signed extremes.
  function automatic logic signed [TimeW-1:0] pick_time();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 7)) - 4;
      4, 5, 6: return $urandom();
      7: return 32'sh7fff_ffff;
      8: return 32'sh8000_0000;
      default: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
    endcase
  endfunction

  // Presents one request word and holds it until the block takes it. With a gap,
  // valid drops after the handshake; without one the next word follows at once.
  task automatic send_word(input logic [1:0] op, input logic [PosW-1:0] pos,
                           input logic signed [TimeW-1:0] due);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.position_number <= pos;
    req_ch.due_time <= due;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    words_sent++;
    case (op)
      tsuq_pkg::OP_INSERT: if (level < Depth) level++;
      tsuq_pkg::OP_POP: if (level > 0) level--;
      tsuq_pkg::OP_CLEAR: level = 0;
      default: ;
    endcase
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The response side stalls at random, with the odd long stretch of no stalls.
  initial begin
    int on_len;
    int off_len;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 8);
      rsp_ch.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      off_len = pick_gap();
      if (off_len > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  // Both channels are sampled at the rising edge, before any driver updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        mirror.note_request(req_ch.operation, req_ch.position_number, req_ch.due_time);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        mirror.check_head(rsp_ch.head_valid, rsp_ch.head_position, rsp_ch.head_time,
                          rsp_ch.entry_count, rsp_ch.rejected);
      end
    end
  end

  // Watchdog: a run in which neither channel moves a word for too long is hung.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HangLimit) begin
      $display("[time_sorted_unload_queue] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int kind;
    int count;
    int k;
    int r;
    words_sent = 0;
    level = 0;
    no_gaps = 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.operation <= tsuq_pkg::OP_INSERT;
    req_ch.position_number <= '0;
    req_ch.due_time <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed part. An empty queue must refuse a pop, and the unused code and a
    // clear must leave it empty.
    send_word(tsuq_pkg::OP_POP, 8'd0, 32'sd0);
    send_word(OpNoEffect, 8'hff, -32'sd1);
    send_word(tsuq_pkg::OP_CLEAR, 8'h00, 32'sd0);
    // Equal due times must leave in arrival order.
    send_word(tsuq_pkg::OP_INSERT, 8'd5, 32'sd10);
    send_word(tsuq_pkg::OP_INSERT, 8'd6, 32'sd10);
    // The latest and the earliest possible due times.
    send_word(tsuq_pkg::OP_INSERT, 8'd7, 32'sh7fff_ffff);
    send_word(tsuq_pkg::OP_INSERT, 8'd8, 32'sh8000_0000);
    // The reserved position is stored like any other and still counts as held.
    send_word(tsuq_pkg::OP_INSERT, 8'hff, -32'sd1);
    send_word(tsuq_pkg::OP_INSERT, 8'h00, 32'sd0);
    send_word(tsuq_pkg::OP_INSERT, 8'haa, 32'sh5555_5555);
    send_word(tsuq_pkg::OP_INSERT, 8'h55, 32'shaaaa_aaaa);
    send_word(OpNoEffect, 8'h12, 32'sd99);
    send_word(tsuq_pkg::OP_POP, 8'h00, 32'sd0);
    send_word(tsuq_pkg::OP_POP, 8'h00, 32'sd0);
    send_word(tsuq_pkg::OP_POP, 8'h00, 32'sd0);
    send_word(tsuq_pkg::OP_CLEAR, 8'hff, -32'sd1);
    send_word(tsuq_pkg::OP_POP, 8'hff, 32'sh7fff_ffff);
    send_word(tsuq_pkg::OP_INSERT, 8'd254, 32'sd3);
    send_word(tsuq_pkg::OP_POP, 8'd1, 32'sd1);

    // Random part, built from episodes: fill past full so that inserts are
    // refused, drain past empty so that pops are refused, and mixed stretches.
    while (words_sent < RandomItems) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        count = Depth - level + $urandom_range(1, 3);
        for (k = 0; k < count; k++) send_word(tsuq_pkg::OP_INSERT, pick_pos(), pick_time());
      end else if (kind < 4) begin
        count = level + $urandom_range(1, 2);
        for (k = 0; k < count; k++) send_word(tsuq_pkg::OP_POP, pick_pos(), $urandom());
      end else begin
        count = $urandom_range(20, 40);
        for (k = 0; k < count; k++) begin
          r = $urandom_range(0, 99);
          if (r < 52) send_word(tsuq_pkg::OP_INSERT, pick_pos(), pick_time());
          else if (r < 88) send_word(tsuq_pkg::OP_POP, pick_pos(), $urandom());
          else if (r < 91) send_word(tsuq_pkg::OP_CLEAR, pick_pos(), $urandom());
          else send_word(OpNoEffect, pick_pos(), $urandom());
        end
      end
    end
    req_ch.valid <= 1'b0;

    // Wait for every predicted response word, then a little longer so that a
    // stray extra word would still be caught. The watchdog bounds both waits.
    while (mirror.pending_heads.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mirror.error_count == 0 && mirror.pending_heads.size() == 0) begin
      $display("[time_sorted_unload_queue] OK");
    end else begin
      $display("[time_sorted_unload_queue] ERROR");
    end
    $finish;
  end

endmodule
